// ----- src/gfba_pkg.sv -----
package gfba_pkg;

    localparam int STACK_DEPTH = 50;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_HDR   = 2'd2;
    localparam logic [1:0] REQ_ENTRY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_BUSY  = 2'd3;

    localparam logic [1:0] KIND_RESP = 2'd0;
    localparam logic [1:0] KIND_HDR  = 2'd1;
    localparam logic [1:0] KIND_ENT  = 2'd2;

    localparam logic [1:0] RS_IDLE = 2'd0;
    localparam logic [1:0] RS_HDR  = 2'd1;
    localparam logic [1:0] RS_RECV = 2'd2;

    localparam logic [1:0] CFG_FIRST = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MAGIC = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] blk_id;
        logic        inc_total;
        logic [31:0] hdr_magic;
        logic [31:0] hdr_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [31:0] res_blk;
        logic [5:0]  word_index;
        logic [31:0] word_value;
        logic [5:0]  hdr_count_out;
        logic        refill_request;
        logic [5:0]  stack_fill;
        logic [31:0] total_free;
        logic        dirty;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic spill_mode;
        logic spill_emit;
    } cmd_t;

    typedef struct packed {
        logic spill_req;
        logic out_free;
        logic spill_last;
    } stat_t;

endpackage

// ----- src/gfba_ctrl.sv -----
module gfba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  gfba_pkg::stat_t stat,
    output gfba_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SPILL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = stat.spill_req ? S_SPILL : S_IDLE;
                end
            end
            S_SPILL:
            begin
                cmd.spill_mode = 1'b1;
                if (stat.out_free)
                begin
                    cmd.spill_emit = 1'b1;
                    if (stat.spill_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/gfba_dp.sv -----
module gfba_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  gfba_pkg::req_t   req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output gfba_pkg::rsp_t   rsp_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  gfba_pkg::cmd_t   cmd,
    output gfba_pkg::stat_t  stat
);

    logic [31:0] mem [0:gfba_pkg::STACK_DEPTH-1];

    gfba_pkg::req_t in_reg;
    logic [31:0] first_reg;
    logic [31:0] limit_reg;
    logic [31:0] magic_reg;

    logic [gfba_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [31:0]                 total_reg, total_next;
    logic                        dirty_reg, dirty_next;
    logic [1:0]                  rs_reg, rs_next;
    logic [gfba_pkg::CNT_W-1:0]  exp_reg, exp_next;
    logic [gfba_pkg::CNT_W-1:0]  pos_reg, pos_next;
    logic [gfba_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [31:0]                 rdata_reg;
    gfba_pkg::rsp_t              out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;

    logic [gfba_pkg::ADDR_W-1:0] rd_addr;
    logic [gfba_pkg::ADDR_W-1:0] pop_addr;
    logic                        wr_en;
    logic [gfba_pkg::ADDR_W-1:0] wr_addr;
    logic [gfba_pkg::CNT_W-1:0]  count_dec;
    logic [31:0]                 total_dec;
    logic [gfba_pkg::CNT_W-1:0]  pos_inc;
    logic                        in_range;
    logic                        hdr_good;
    logic                        spill_last;
    gfba_pkg::rsp_t              res;

    assign in_range  = (in_reg.blk_id >= first_reg) && (in_reg.blk_id < limit_reg);
    assign count_dec = count_reg - gfba_pkg::CNT_W'(1);
    assign total_dec = total_reg - 32'd1;
    assign pos_inc   = pos_reg + gfba_pkg::CNT_W'(1);
    assign hdr_good  = (in_reg.hdr_magic == magic_reg) && (in_reg.hdr_count != 32'd0)
                       && (in_reg.hdr_count <= 32'(gfba_pkg::STACK_DEPTH));
    assign pop_addr  = (count_reg == '0) ? '0 : gfba_pkg::ADDR_W'(count_dec);
    assign spill_last = (idx_reg == gfba_pkg::ADDR_W'(gfba_pkg::STACK_DEPTH - 1));

    assign stat.out_free   = !out_valid_reg || !rsp_stall;
    assign stat.spill_last = spill_last;
    assign stat.spill_req  = (in_reg.req_type == gfba_pkg::REQ_FREE)
                             && (rs_reg == gfba_pkg::RS_IDLE)
                             && in_range
                             && (count_reg >= gfba_pkg::CNT_W'(gfba_pkg::STACK_DEPTH));

    // spill walk index; the read address takes the next index value, so the registered read data lines up with it
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.commit)
        begin
            idx_next = '0;
        end
        else if (cmd.spill_emit)
        begin
            idx_next = spill_last ? '0 : idx_reg + gfba_pkg::ADDR_W'(1);
        end
        rd_addr = (cmd.spill_mode || cmd.commit) ? idx_next : pop_addr;
    end

    always_comb
    begin
        res            = '0;
        res.last       = 1'b1;
        count_next     = count_reg;
        total_next     = total_reg;
        dirty_next     = dirty_reg;
        rs_next        = rs_reg;
        exp_next       = exp_reg;
        pos_next       = pos_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        if (cmd.commit)
        begin
            unique case (in_reg.req_type)
                gfba_pkg::REQ_ALLOC:
                begin
                    if (rs_reg != gfba_pkg::RS_IDLE)
                    begin
                        res.status = gfba_pkg::ST_BUSY;
                    end
                    else if (total_reg == 32'd0 || count_reg == '0)
                    begin
                        res.status = gfba_pkg::ST_NONE;
                    end
                    else
                    begin
                        count_next  = count_dec;
                        total_next  = total_dec;
                        dirty_next  = 1'b1;
                        res.res_blk = rdata_reg;
                        if (count_dec == '0 && total_dec != 32'd0)
                        begin
                            res.refill_request = 1'b1;
                            rs_next            = gfba_pkg::RS_HDR;
                        end
                    end
                end
                gfba_pkg::REQ_FREE:
                begin
                    if (rs_reg != gfba_pkg::RS_IDLE)
                    begin
                        res.status = gfba_pkg::ST_BUSY;
                    end
                    else if (!in_range)
                    begin
                        res.status = gfba_pkg::ST_RANGE;
                    end
                    else
                    begin
                        dirty_next = 1'b1;
                        if (in_reg.inc_total && total_reg != '1)
                        begin
                            total_next = total_reg + 32'd1;
                        end
                        if (stat.spill_req)
                        begin
                            // header beat first; the new block lands at entry 0 after the walk
                            count_next        = gfba_pkg::CNT_W'(1);
                            res.kind          = gfba_pkg::KIND_HDR;
                            res.res_blk       = in_reg.blk_id;
                            res.word_value    = magic_reg;
                            res.hdr_count_out = gfba_pkg::CNT_W'(gfba_pkg::STACK_DEPTH);
                            res.last          = 1'b0;
                        end
                        else
                        begin
                            count_next = count_reg + gfba_pkg::CNT_W'(1);
                            wr_en      = 1'b1;
                            wr_addr    = gfba_pkg::ADDR_W'(count_reg);
                        end
                    end
                end
                gfba_pkg::REQ_HDR:
                begin
                    if (rs_reg != gfba_pkg::RS_HDR)
                    begin
                        res.status = gfba_pkg::ST_BUSY;
                    end
                    else
                    begin
                        rs_next  = gfba_pkg::RS_IDLE;
                        exp_next = '0;
                        pos_next = '0;
                        if (hdr_good)
                        begin
                            rs_next  = gfba_pkg::RS_RECV;
                            exp_next = gfba_pkg::CNT_W'(in_reg.hdr_count);
                        end
                    end
                end
                gfba_pkg::REQ_ENTRY:
                begin
                    if (rs_reg != gfba_pkg::RS_RECV
                        || pos_reg >= gfba_pkg::CNT_W'(gfba_pkg::STACK_DEPTH))
                    begin
                        res.status = gfba_pkg::ST_BUSY;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = gfba_pkg::ADDR_W'(pos_reg);
                        pos_next   = pos_inc;
                        count_next = pos_inc;
                        if (pos_inc >= exp_reg)
                        begin
                            rs_next  = gfba_pkg::RS_IDLE;
                            exp_next = '0;
                            pos_next = '0;
                        end
                    end
                end
                default:
                begin
                    res.status = gfba_pkg::ST_BUSY;
                end
            endcase
            res.stack_fill = count_next;
            res.total_free = total_next;
            res.dirty      = dirty_next;
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (cmd.spill_emit)
        begin
            out_next            = '0;
            out_next.kind       = gfba_pkg::KIND_ENT;
            out_next.res_blk    = in_reg.blk_id;
            out_next.word_index = 6'(idx_reg);
            out_next.word_value = rdata_reg;
            out_next.stack_fill = count_reg;
            out_next.total_free = total_reg;
            out_next.dirty      = dirty_reg;
            out_next.last       = spill_last;
            out_valid_next      = 1'b1;
            if (spill_last)
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_reg.blk_id;
        end
        rdata_reg <= mem[rd_addr];
        out_reg   <= out_next;
        if (cmd.load_in)
        begin
            in_reg <= req_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 32'd0;
            limit_reg     <= '1;
            magic_reg     <= 32'd0;
            count_reg     <= '0;
            total_reg     <= 32'd0;
            dirty_reg     <= 1'b0;
            rs_reg        <= gfba_pkg::RS_IDLE;
            exp_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gfba_pkg::CFG_FIRST: first_reg <= cfg_data;
                    gfba_pkg::CFG_LIMIT: limit_reg <= cfg_data;
                    gfba_pkg::CFG_MAGIC: magic_reg <= cfg_data;
                    default:             ;
                endcase
            end
            count_reg     <= count_next;
            total_reg     <= total_next;
            dirty_reg     <= dirty_next;
            rs_reg        <= rs_next;
            exp_reg       <= exp_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// ----- src/grouped_free_block_allocator_top.sv -----
// A request beat is captured in the input register and executed once the output register
//   can take the result, which is then held in the output register.
// One request at a time: req_stall stays high from acceptance until the request is done, spill walk included.
// A free onto a full stack adds a spill walk over every stack entry (50),
//   one memory read per entry beat, which output stalls can hold.
// Reset (rst_n, async low) clears control and counters; stack memory is not cleared.
module grouped_free_block_allocator_top (
    input  logic           clk,
    input  logic           rst_n,
    // request channel: a beat moves when valid is high and stall is low
    input  logic           req_valid,
    output logic           req_stall,
    input  gfba_pkg::req_t req_data,
    // result channel: results of one request come in order, last marks the final beat
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output gfba_pkg::rsp_t rsp_data,
    // configuration write channel, always ready; write only while idle
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    gfba_pkg::cmd_t  cmd;
    gfba_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer: idle, execute, spill walk
    gfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // stack memory, counters, refill tracking, config registers and output register
    gfba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- src/gfba_checker.sv -----
module gfba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input gfba_pkg::rsp_t rsp_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result beat changed");

    // one request at a time: stall follows every accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while busy");

    // a header beat opens a spill and never ends the request
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.kind == gfba_pkg::KIND_HDR |->
            !rsp_data.last && rsp_data.status == gfba_pkg::ST_OK)
        else $error("bad spill header beat");

    // plain responses always end the request
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.kind == gfba_pkg::KIND_RESP |-> rsp_data.last)
        else $error("response without last");

    // a refill is asked for only when the stack ran dry with blocks remaining
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.refill_request |->
            rsp_data.stack_fill == 6'd0 && rsp_data.total_free != 32'd0)
        else $error("refill request with inconsistent state");

endmodule

bind grouped_free_block_allocator_top gfba_checker u_gfba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

// ----- bench/grouped_free_block_allocator_top_tb.sv -----
`timescale 1ns / 1ps

module grouped_free_block_allocator_top_tb;

    // Generous ceiling for ~400 requests, a handful of 51-beat spills, random
    // output stalls and one long hold-off.
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    // Extra cycles after the last awaited beat, to catch stray results.
    localparam int TAIL_CYCLES = 20;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    gfba_pkg::req_t req_data  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    gfba_pkg::rsp_t rsp_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = gfba_pkg::CFG_FIRST;
    logic [31:0]    cfg_data  = '0;

    // Handshake shaping flags, owned by the request side.
    logic        hold_req = 1'b0;
    logic        calm     = 1'b0;

    // Result beats still owed by the block, oldest first.
    gfba_pkg::rsp_t awaited[$];
    int          mismatches  = 0;
    int          cycle_count = 0;

    // Shadow of the allocator: configuration and state.
    logic [31:0] cfg_first = '0;
    logic [31:0] cfg_limit = '1;
    logic [31:0] cfg_magic = '0;
    logic [31:0] stk [gfba_pkg::STACK_DEPTH];
    int unsigned fill        = 0;
    logic [31:0] free_total  = '0;
    logic        dirty_m     = 1'b0;
    logic [1:0]  refill_st   = gfba_pkg::RS_IDLE;
    int unsigned refill_need = 0;
    int unsigned refill_pos  = 0;

    // Stimulus steering: set on a spill, flips the generator into draining.
    bit          spilled_flag = 1'b0;
    bit          draining     = 1'b0;

    typedef struct {
        gfba_pkg::req_t req;
        bit             typed;
        logic [1:0]     status;
    } step_row_t;

    step_row_t   directed_steps[$];

    grouped_free_block_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build one result beat; the state fields reflect the shadow after the request.
    function automatic gfba_pkg::rsp_t compose(logic [1:0] status, logic [1:0] kind,
                                               logic [31:0] blk, logic [5:0] widx,
                                               logic [31:0] wval, logic [5:0] hcnt,
                                               logic rreq, logic fin);
        gfba_pkg::rsp_t o;
        o.status         = status;
        o.kind           = kind;
        o.res_blk        = blk;
        o.word_index     = widx;
        o.word_value     = wval;
        o.hdr_count_out  = hcnt;
        o.refill_request = rreq;
        o.stack_fill     = 6'(fill);
        o.total_free     = free_total;
        o.dirty          = dirty_m;
        o.last           = fin;
        return o;
    endfunction

    // Advance the shadow by one accepted request and queue the beats it owes.
    task automatic allocator_step(input gfba_pkg::req_t r);
        logic [31:0] snap [gfba_pkg::STACK_DEPTH];
        logic [31:0] got;
        logic        rreq;
        bit          spill;
        case (r.req_type)
            gfba_pkg::REQ_ALLOC:
            begin
                if (refill_st != gfba_pkg::RS_IDLE)
                    awaited.push_back(compose(gfba_pkg::ST_BUSY, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                else if (free_total == 0 || fill == 0)
                    awaited.push_back(compose(gfba_pkg::ST_NONE, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                else
                begin
                    fill--;
                    got  = stk[fill];
                    free_total--;
                    rreq = 1'b0;
                    // Stack ran dry while the disk still has free blocks: fetch next group.
                    if (fill == 0 && free_total != 0)
                    begin
                        rreq      = 1'b1;
                        refill_st = gfba_pkg::RS_HDR;
                    end
                    dirty_m = 1'b1;
                    awaited.push_back(compose(gfba_pkg::ST_OK, gfba_pkg::KIND_RESP,
                                              got, '0, '0, '0, rreq, 1'b1));
                end
            end
            gfba_pkg::REQ_FREE:
            begin
                if (refill_st != gfba_pkg::RS_IDLE)
                    awaited.push_back(compose(gfba_pkg::ST_BUSY, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                else if (r.blk_id < cfg_first || r.blk_id >= cfg_limit)
                    awaited.push_back(compose(gfba_pkg::ST_RANGE, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                else
                begin
                    spill = (fill >= gfba_pkg::STACK_DEPTH);
                    if (spill)
                    begin
                        snap = stk;
                        fill = 0;
                    end
                    stk[fill] = r.blk_id;
                    fill++;
                    if (r.inc_total && free_total != '1)
                        free_total++;
                    dirty_m = 1'b1;
                    if (!spill)
                        awaited.push_back(compose(gfba_pkg::ST_OK, gfba_pkg::KIND_RESP,
                                                  '0, '0, '0, '0, 1'b0, 1'b1));
                    else
                    begin
                        // Full stack: write it out to the freed block, header first.
                        awaited.push_back(compose(gfba_pkg::ST_OK, gfba_pkg::KIND_HDR,
                                                  r.blk_id, '0, cfg_magic,
                                                  6'(gfba_pkg::STACK_DEPTH), 1'b0, 1'b0));
                        for (int i = 0; i < gfba_pkg::STACK_DEPTH; i++)
                            awaited.push_back(compose(gfba_pkg::ST_OK, gfba_pkg::KIND_ENT,
                                                      r.blk_id, 6'(i), snap[i], '0, 1'b0,
                                                      i == gfba_pkg::STACK_DEPTH - 1));
                        spilled_flag = 1'b1;
                    end
                end
            end
            gfba_pkg::REQ_HDR:
            begin
                if (refill_st != gfba_pkg::RS_HDR)
                    awaited.push_back(compose(gfba_pkg::ST_BUSY, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                else
                begin
                    refill_st   = gfba_pkg::RS_IDLE;
                    refill_need = 0;
                    refill_pos  = 0;
                    // A bad magic or oversized count drops the group; an empty one ends here.
                    if (r.hdr_magic == cfg_magic && r.hdr_count != 0 &&
                        r.hdr_count <= gfba_pkg::STACK_DEPTH)
                    begin
                        refill_st   = gfba_pkg::RS_RECV;
                        refill_need = r.hdr_count;
                    end
                    awaited.push_back(compose(gfba_pkg::ST_OK, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                end
            end
            default:
            begin
                if (refill_st != gfba_pkg::RS_RECV || refill_pos >= gfba_pkg::STACK_DEPTH)
                    awaited.push_back(compose(gfba_pkg::ST_BUSY, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                else
                begin
                    stk[refill_pos] = r.blk_id;
                    refill_pos++;
                    fill = refill_pos;
                    if (refill_pos >= refill_need)
                    begin
                        refill_st   = gfba_pkg::RS_IDLE;
                        refill_need = 0;
                        refill_pos  = 0;
                    end
                    awaited.push_back(compose(gfba_pkg::ST_OK, gfba_pkg::KIND_RESP,
                                              '0, '0, '0, '0, 1'b0, 1'b1));
                end
            end
        endcase
    endtask

    // Mostly legal block numbers, with the range edges and a share of rejects.
    function automatic logic [31:0] pick_block();
        int unsigned roll;
        roll = $urandom_range(99);
        if (cfg_limit > cfg_first && roll < 90)
        begin
            if (roll < 8)
                return cfg_first;
            if (roll < 16)
                return cfg_limit - 1;
            return $urandom_range(cfg_limit - 1, cfg_first);
        end
        case (roll % 4)
            0:       return cfg_limit;
            1:       return cfg_first - 1;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pick the next request from the shadow state: fill until a spill, then
    // drain into refills; answer refill requests with well-formed groups most
    // of the time, and sprinkle misplaced requests throughout.
    function automatic gfba_pkg::req_t pick_request();
        gfba_pkg::req_t r;
        int unsigned    roll;
        r.req_type  = gfba_pkg::REQ_ALLOC;
        r.blk_id    = $urandom;
        r.inc_total = ($urandom_range(99) < 80);
        r.hdr_magic = $urandom;
        r.hdr_count = $urandom;
        roll        = $urandom_range(99);
        if (refill_st == gfba_pkg::RS_HDR && roll < 85)
        begin
            r.req_type = gfba_pkg::REQ_HDR;
            if ($urandom_range(9) != 0)
                r.hdr_magic = cfg_magic;
            roll = $urandom_range(99);
            if (roll < 70)
                r.hdr_count = $urandom_range(gfba_pkg::STACK_DEPTH, 1);
            else if (roll < 80)
                r.hdr_count = 0;
            else if (roll < 90)
                r.hdr_count = gfba_pkg::STACK_DEPTH + $urandom_range(13, 1);
        end
        else if (refill_st == gfba_pkg::RS_RECV && roll < 90)
        begin
            r.req_type = gfba_pkg::REQ_ENTRY;
            r.blk_id   = pick_block();
        end
        else if (refill_st != gfba_pkg::RS_IDLE)
            r.req_type = 2'($urandom_range(3));
        else
        begin
            if (draining && fill == 0)
                draining = 1'b0;
            if (!draining && spilled_flag)
            begin
                draining     = 1'b1;
                spilled_flag = 1'b0;
            end
            if (roll < 5)
                r.req_type = $urandom_range(1) ? gfba_pkg::REQ_HDR : gfba_pkg::REQ_ENTRY;
            else if (roll < (draining ? 20 : 85))
            begin
                r.req_type = gfba_pkg::REQ_FREE;
                r.blk_id   = pick_block();
            end
        end
        return r;
    endfunction

    function automatic void add_step(logic [1:0] kind, logic [31:0] blk, logic ct,
                                     logic [31:0] magic, logic [31:0] cnt,
                                     bit typed, logic [1:0] status);
        step_row_t s;
        s.req.req_type  = kind;
        s.req.blk_id    = blk;
        s.req.inc_total = ct;
        s.req.hdr_magic = magic;
        s.req.hdr_count = cnt;
        s.typed         = typed;
        s.status        = status;
        directed_steps.push_back(s);
    endfunction

    // Offer one request beat, hold it until accepted, then update the shadow.
    // Valid is only lowered when an idle gap follows, never toggled in one step.
    task automatic send_request(input gfba_pkg::req_t r);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 25)
            gap = $urandom_range(4, 1);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        allocator_step(r);
    endtask

    // Present one register write and hold it until taken; the caller drops valid.
    task automatic put_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            gfba_pkg::CFG_FIRST: cfg_first = val;
            gfba_pkg::CFG_LIMIT: cfg_limit = val;
            default:             cfg_magic = val;
        endcase
    endtask

    // Drain, reprogram all three registers, then run a random stretch.
    task automatic run_phase(input logic [31:0] f, input logic [31:0] l, input logic [31:0] m,
                             input int items, input bit squeeze, input bit quiet);
        req_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        put_reg(gfba_pkg::CFG_FIRST, f);
        put_reg(gfba_pkg::CFG_LIMIT, l);
        put_reg(gfba_pkg::CFG_MAGIC, m);
        cfg_valid <= 1'b0;
        for (int k = 0; k < items; k++)
        begin
            // Long output hold-off while requests keep coming: back up the block.
            if (squeeze && k == 40)
                hold_req <= 1'b1;
            calm <= quiet && k >= 30 && k < 110;
            send_request(pick_request());
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            // report the first couple hundred, count them all
            if (mismatches < 200)
                $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result(gfba_pkg::rsp_t want, gfba_pkg::rsp_t got);
        check_field("status", want.status, got.status);
        check_field("kind", want.kind, got.kind);
        check_field("res_blk", want.res_blk, got.res_blk);
        check_field("word_index", want.word_index, got.word_index);
        check_field("word_value", want.word_value, got.word_value);
        check_field("hdr_count_out", want.hdr_count_out, got.hdr_count_out);
        check_field("refill_request", want.refill_request, got.refill_request);
        check_field("stack_fill", want.stack_fill, got.stack_fill);
        check_field("total_free", want.total_free, got.total_free);
        check_field("dirty", want.dirty, got.dirty);
        check_field("last", want.last, got.last);
    endfunction

    // Result side: check each accepted beat against the oldest awaited one,
    // then pick the stall for the next cycle (random, quiet, or held off).
    initial
    begin
        gfba_pkg::rsp_t want;
        int             hold_left;
        bit             hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
            begin
                if (awaited.size() == 0)
                begin
                    if (mismatches < 200)
                        $error("result beat with nothing awaited: %p", rsp_data);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    check_result(want, rsp_data);
                end
            end
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (calm)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99) < 25);
        end
    end

    // Watchdog: count cycles and bail out if the run never settles.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Request side: reset, directed table, then random phases across settings.
    initial
    begin
        step_row_t      s;
        gfba_pkg::rsp_t fixed;

        // Directed table, under the reset settings (whole range, magic 0).
        // Typed rows all hit the untouched reset state: only status and last set.
        add_step(gfba_pkg::REQ_ALLOC, 32'h0, 1'b0, 32'h0, 32'h0, 1'b1, gfba_pkg::ST_NONE);
        add_step(gfba_pkg::REQ_HDR, 32'h0, 1'b0, 32'h0, 32'h1, 1'b1, gfba_pkg::ST_BUSY);
        add_step(gfba_pkg::REQ_ENTRY, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h0,
                 1'b1, gfba_pkg::ST_BUSY);
        add_step(gfba_pkg::REQ_FREE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b1, gfba_pkg::ST_RANGE);
        add_step(gfba_pkg::REQ_FREE, 32'h0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_FREE, 32'hFFFF_FFFE, 1'b0, 32'h0, 32'h0, 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b0, gfba_pkg::ST_OK);
        // stack holds one block but the total is zero
        add_step(gfba_pkg::REQ_ALLOC, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_FREE, 32'h8000_0000, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA,
                 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_FREE, 32'h7FFF_FFFF, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555,
                 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_ALLOC, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_ALLOC, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_ALLOC, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_HDR, 32'h0, 1'b0, 32'h0, 32'd50, 1'b0, gfba_pkg::ST_OK);
        add_step(gfba_pkg::REQ_ENTRY, 32'h1234_5678, 1'b0, 32'h0, 32'h0, 1'b0, gfba_pkg::ST_OK);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[n])
        begin
            s = directed_steps[n];
            send_request(s.req);
            if (s.typed)
            begin
                // swap the shadow's beat for the hand-written one
                fixed        = '0;
                fixed.status = s.status;
                fixed.last   = 1'b1;
                void'(awaited.pop_back());
                awaited.push_back(fixed);
            end
        end

        // Narrow range, arbitrary magic; long hold-off early on.
        run_phase(32'd16, 32'h0000_1000, 32'hC0DE_F00D, 140, 1'b1, 1'b0);
        // Full range, all-ones magic; a quiet stretch with no idling.
        run_phase(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 140, 1'b0, 1'b1);
        // Empty range at the extremes: every free is rejected.
        run_phase(32'hFFFF_FFFF, 32'h0, 32'h1234_5678, 30, 1'b0, 1'b0);
        // Single legal block, zero magic.
        run_phase(32'h0, 32'h1, 32'h0, 70, 1'b0, 1'b0);

        req_valid <= 1'b0;
        calm      <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
